// ===== rtl/sobel_pkg.sv =====
package sobel_pkg;

  localparam int unsigned CFG_W = 11;

  localparam logic [7:0] EDGE_ON  = 8'hFF;
  localparam logic [7:0] EDGE_OFF = 8'h00;

  // one column of the window as it enters, with the results it causes
  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] pix;
    logic       first_col;
    logic [3:0] mask;
    logic [9:0] row;
    logic [9:0] col;
  } col_word_t;

  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [9:0]         row;
    logic [9:0]         col;
    logic               last;
  } grad_t;

endpackage

// ===== rtl/sobel_line_buf.sv =====
module sobel_line_buf #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_upper_i,
  input  logic [7:0]    wr_middle_i,
  output logic [7:0]    rd_upper_o,
  output logic [7:0]    rd_middle_o
);

  logic [7:0] upper_mem [DEPTH];
  logic [7:0] middle_mem [DEPTH];
  logic [7:0] rd_upper_q;
  logic [7:0] rd_middle_q;
  logic       fwd;

  assign fwd = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= wr_upper_i;
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
  end

  // same-entry write in the read cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (fwd) begin
        rd_upper_q  <= wr_upper_i;
        rd_middle_q <= wr_middle_i;
      end else begin
        rd_upper_q  <= upper_mem[rd_addr_i];
        rd_middle_q <= middle_mem[rd_addr_i];
      end
    end
  end

  assign rd_upper_o  = rd_upper_q;
  assign rd_middle_o = rd_middle_q;

endmodule

// ===== rtl/sobel_window.sv =====
module sobel_window import sobel_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      col_valid_i,
  input  col_word_t col_i,
  output logic      col_ready_o,
  output logic      grad_valid_o,
  output grad_t     grad_o,
  input  logic      grad_ready_i
);

  logic [7:0] win_q [3][3];
  logic [7:0] wc [3][3];
  logic [7:0] ws [3][3];
  logic [3:0] mask_q;
  logic       busy_q;
  logic [9:0] row_q;
  logic [9:0] col_q;
  logic       grad_valid_q;
  grad_t      grad_q;

  logic       en_out;
  logic       issue;
  logic       load;
  logic [1:0] pick;
  logic [3:0] rem;
  logic [9:0] lsum, rsum, tsum, bsum;

  assign en_out      = !grad_valid_q || grad_ready_i;
  assign issue       = busy_q && en_out;
  assign col_ready_o = !busy_q || (issue && (rem == 4'b0000));
  assign load        = col_valid_i && col_ready_o;

  always_comb begin
    if (mask_q[0]) begin
      pick = 2'd0;
    end else if (mask_q[1]) begin
      pick = 2'd1;
    end else if (mask_q[2]) begin
      pick = 2'd2;
    end else begin
      pick = 2'd3;
    end
    rem = mask_q & ~(4'b0001 << pick);
  end

  // replicate right column and bottom row where the result sits on the border
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wc[0][i] = pick[0] ? win_q[1][i] : win_q[0][i];
      wc[1][i] = pick[0] ? win_q[2][i] : win_q[1][i];
      wc[2][i] = win_q[2][i];
    end
    for (int j = 0; j < 3; j++) begin
      ws[j][0] = pick[1] ? wc[j][1] : wc[j][0];
      ws[j][1] = pick[1] ? wc[j][2] : wc[j][1];
      ws[j][2] = wc[j][2];
    end
    lsum = {2'b00, ws[0][0]} + {1'b0, ws[0][1], 1'b0} + {2'b00, ws[0][2]};
    rsum = {2'b00, ws[2][0]} + {1'b0, ws[2][1], 1'b0} + {2'b00, ws[2][2]};
    tsum = {2'b00, ws[0][0]} + {1'b0, ws[1][0], 1'b0} + {2'b00, ws[2][0]};
    bsum = {2'b00, ws[0][2]} + {1'b0, ws[1][2], 1'b0} + {2'b00, ws[2][2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          win_q[j][i] <= 8'd0;
        end
      end
    end else if (load) begin
      if (col_i.first_col) begin
        for (int j = 0; j < 3; j++) begin
          win_q[j][0] <= col_i.top;
          win_q[j][1] <= col_i.mid;
          win_q[j][2] <= col_i.pix;
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          win_q[0][i] <= win_q[1][i];
          win_q[1][i] <= win_q[2][i];
        end
        win_q[2][0] <= col_i.top;
        win_q[2][1] <= col_i.mid;
        win_q[2][2] <= col_i.pix;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mask_q <= 4'b0000;
    end else if (load) begin
      busy_q <= |col_i.mask;
      mask_q <= col_i.mask;
    end else if (issue) begin
      busy_q <= |rem;
      mask_q <= rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q <= col_i.row;
      col_q <= col_i.col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grad_valid_q <= 1'b0;
    end else if (en_out) begin
      grad_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      grad_q.gx   <= $signed({1'b0, rsum}) - $signed({1'b0, lsum});
      grad_q.gy   <= $signed({1'b0, bsum}) - $signed({1'b0, tsum});
      grad_q.row  <= pick[1] ? row_q : row_q - 10'd1;
      grad_q.col  <= pick[0] ? col_q : col_q - 10'd1;
      grad_q.last <= (rem == 4'b0000);
    end
  end

  assign grad_valid_o = grad_valid_q;
  assign grad_o       = grad_q;

endmodule

// ===== rtl/sobel_mag.sv =====
module sobel_mag import sobel_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] thr_i,
  input  logic             grad_valid_i,
  input  grad_t            grad_i,
  output logic             grad_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       edge_value_o,
  output logic [9:0]       out_row_o,
  output logic [9:0]       out_col_o,
  output logic             last_of_run_o
);

  logic               sq_valid_q;
  logic [19:0]        sqx_q, sqy_q;
  logic [9:0]         sq_row_q, sq_col_q;
  logic               sq_last_q;
  logic [21:0]        tsq_q;
  logic signed [21:0] gx2, gy2;
  logic [20:0]        mag2;
  logic               out_valid_q;
  logic [7:0]         edge_q;
  logic [9:0]         row_q, col_q;
  logic               last_q;
  logic               en_sq, en_out;

  assign en_out       = !out_valid_q || out_ready_i;
  assign en_sq        = !sq_valid_q || en_out;
  assign grad_ready_o = en_sq;

  assign gx2  = 22'(grad_i.gx) * 22'(grad_i.gx);
  assign gy2  = 22'(grad_i.gy) * 22'(grad_i.gy);
  assign mag2 = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i) begin
    tsq_q <= 22'(thr_i) * 22'(thr_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (en_sq) begin
      sq_valid_q <= grad_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_sq && grad_valid_i) begin
      sqx_q     <= gx2[19:0];
      sqy_q     <= gy2[19:0];
      sq_row_q  <= grad_i.row;
      sq_col_q  <= grad_i.col;
      sq_last_q <= grad_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && sq_valid_q) begin
      edge_q <= ({1'b0, mag2} > tsq_q) ? EDGE_ON : EDGE_OFF;
      row_q  <= sq_row_q;
      col_q  <= sq_col_q;
      last_q <= sq_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign edge_value_o  = edge_q;
  assign out_row_o     = row_q;
  assign out_col_o     = col_q;
  assign last_of_run_o = last_q;

endmodule

// ===== rtl/sobel_edge_threshold.sv =====
// path: a pixel passes the input register, the window, then the gradient, squares and output registers
// throughput: one pixel per cycle unless the output stalls; a pixel causing n results
//   (n up to 4, at last column or row) holds the input while the single gradient unit issues them
// line stores: one read and one write per pixel on a registered-read memory port
// reset: counters and window cleared, registers to 640 x 480 and threshold 50;
//   line stores are not cleared and need no clearing pass
module sobel_edge_threshold import sobel_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       pixel_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       edge_value_o,
  output logic [9:0]       out_row_o,
  output logic [9:0]       out_col_o,
  output logic             last_of_run_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  localparam logic [1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 11'd480;
  localparam logic [CFG_W-1:0] RST_EDGE_THRESHOLD = 11'd50;

  logic [CFG_W-1:0] width_q, height_q, thr_q;
  logic [CW-1:0]    col_q, col_last;
  logic [RW-1:0]    row_q, row_last;
  logic             last_col, last_row, accept;

  logic             s1_valid_q;
  logic [7:0]       s1_pix_q;
  logic [CW-1:0]    s1_addr_q;
  logic [9:0]       s1_row_q, s1_col_q;
  logic             s1_first_q, s1_rge1_q, s1_rge2_q;
  logic [3:0]       s1_mask_q;

  logic [7:0]       rd_upper, rd_middle;
  logic             col_ready;
  col_word_t        col_word;
  logic             grad_valid, grad_ready;
  grad_t            grad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_FRAME_WIDTH;
      height_q <= RST_FRAME_HEIGHT;
      thr_q    <= RST_EDGE_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:    width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT:   height_q <= cfg_data_i;
        CFG_EDGE_THRESHOLD: thr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // last column and row index, zero treated as one, clamped to the maximum
  always_comb begin
    if (width_q == '0) begin
      col_last = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      col_last = CW'(MAX_WIDTH - 1);
    end else begin
      col_last = CW'(width_q - 11'd1);
    end
    if (height_q == '0) begin
      row_last = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      row_last = RW'(MAX_HEIGHT - 1);
    end else begin
      row_last = RW'(height_q - 11'd1);
    end
  end

  assign last_col   = col_q >= col_last;
  assign last_row   = row_q >= row_last;
  assign in_ready_o = !s1_valid_q || col_ready;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !col_ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q     <= pixel_i;
      s1_addr_q    <= col_q;
      s1_row_q     <= 10'(row_q);
      s1_col_q     <= 10'(col_q);
      s1_first_q   <= (col_q == '0);
      s1_rge1_q    <= (row_q != '0);
      s1_rge2_q    <= (row_q > RW'(1));
      s1_mask_q[0] <= (row_q != '0) && (col_q != '0);
      s1_mask_q[1] <= (row_q != '0) && last_col;
      s1_mask_q[2] <= last_row && (col_q != '0);
      s1_mask_q[3] <= last_row && last_col;
    end
  end

  sobel_line_buf #(
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_i  (col_q),
    .wr_en_i    (s1_valid_q && col_ready),
    .wr_addr_i  (s1_addr_q),
    .wr_upper_i (rd_middle),
    .wr_middle_i(s1_pix_q),
    .rd_upper_o (rd_upper),
    .rd_middle_o(rd_middle)
  );

  // rows above the frame replicate the top row
  always_comb begin
    col_word.pix       = s1_pix_q;
    col_word.mid       = s1_rge1_q ? rd_middle : s1_pix_q;
    col_word.top       = s1_rge2_q ? rd_upper : col_word.mid;
    col_word.first_col = s1_first_q;
    col_word.mask      = s1_mask_q;
    col_word.row       = s1_row_q;
    col_word.col       = s1_col_q;
  end

  sobel_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_valid_i (s1_valid_q),
    .col_i       (col_word),
    .col_ready_o (col_ready),
    .grad_valid_o(grad_valid),
    .grad_o      (grad),
    .grad_ready_i(grad_ready)
  );

  sobel_mag u_mag (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thr_i        (thr_q),
    .grad_valid_i (grad_valid),
    .grad_i       (grad),
    .grad_ready_o (grad_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .edge_value_o (edge_value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

// ===== rtl/sobel_chk.sv =====
module sobel_chk import sobel_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [7:0]       edge_value_o,
  input logic [9:0]       out_row_o,
  input logic [9:0]       out_col_o,
  input logic             last_of_run_o
);

  logic out_fire;

  assign out_fire = out_valid_o && out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(edge_value_o) && $stable(out_row_o)
      && $stable(out_col_o) && $stable(last_of_run_o))
    else $error("output word changed while stalled");

  // the rest of a run follows with no gap
  a_run_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_of_run_o |=> out_valid_o)
    else $error("run broken before its last word");

  a_run_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_of_run_o |=>
      (out_row_o == $past(out_row_o)) || (out_row_o == $past(out_row_o) + 10'd1))
    else $error("row jump inside a run");

  a_edge_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (edge_value_o == EDGE_ON) || (edge_value_o == EDGE_OFF))
    else $error("edge value not binary");

endmodule

bind sobel_edge_threshold sobel_chk u_chk (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import sobel_pkg::*;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;
  localparam logic [1:0] REG_SPARE  = 2'd3;
  localparam int unsigned DIM_MAX = 1024;
  localparam int DIR_ROWS = 33;

  typedef struct packed {
    logic [7:0] mark;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } edge_word_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       idx;
    logic [CFG_W-1:0] data;
    logic [7:0]       pix;
    logic [2:0]       n_typed;
    logic [7:0]       mark0;
    logic [7:0]       mark1;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [7:0]       pixel_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [7:0]       edge_value_o;
  logic [9:0]       out_row_o;
  logic [9:0]       out_col_o;
  logic             last_of_run_o;

  sobel_edge_threshold dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_value_o  (edge_value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .last_of_run_o (last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  // own copy of the detector state
  logic [CFG_W-1:0] cfg_width = 11'd640;
  logic [CFG_W-1:0] cfg_height = 11'd480;
  logic [CFG_W-1:0] cfg_thresh = 11'd50;
  logic [7:0]       line_top [DIM_MAX];
  logic [7:0]       line_mid [DIM_MAX];
  logic [7:0]       win [3][3];
  int unsigned      at_row = 0;
  int unsigned      at_col = 0;

  edge_word_t step_words[$];
  edge_word_t edge_words_due[$];
  edge_word_t got_words[$];
  dir_row_t   dir_tab [DIR_ROWS];

  int   errors = 0;
  int   pixels_sent = 0;
  int   words_checked = 0;
  int   edges_seen = 0;
  bit   idling = 1'b1;
  bit   gentle = 1'b0;
  int   hold_left = 0;
  logic [7:0] last_pix = 8'd128;

  initial begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = 8'd0;
  end

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  // low_rows: rows (mid, cur, cur); right_cols: cols (1, 2, 2)
  function automatic logic [7:0] grad_edge(bit low_rows, bit right_cols);
    int gx, gy, wk, rk, ck, r0, c0, k;
    r0 = low_rows ? 1 : 0;
    c0 = right_cols ? 1 : 0;
    gx = 0;
    gy = 0;
    for (k = 0; k < 3; k++) begin
      rk = low_rows ? ((k == 0) ? 1 : 2) : k;
      ck = right_cols ? ((k == 0) ? 1 : 2) : k;
      wk = (k == 1) ? 2 : 1;
      gx += wk * (int'(win[2][rk]) - int'(win[c0][rk]));
      gy += wk * (int'(win[ck][2]) - int'(win[ck][r0]));
    end
    return (gx * gx + gy * gy > int'(cfg_thresh) * int'(cfg_thresh)) ? EDGE_ON : EDGE_OFF;
  endfunction

  function automatic void add_word(bit low_rows, bit right_cols, int unsigned r,
                                   int unsigned c);
    edge_word_t w;
    w.mark = grad_edge(low_rows, right_cols);
    w.row = 10'(r);
    w.col = 10'(c);
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void sobel_step(logic [7:0] p);
    int unsigned w, h, r, c, idx;
    logic [7:0] mid, top;
    bit lastc, lastr;
    w = eff_dim(cfg_width);
    h = eff_dim(cfg_height);
    r = at_row;
    c = at_col;
    lastc = (c >= w - 1);
    lastr = (r >= h - 1);
    idx = (c < DIM_MAX) ? c : DIM_MAX - 1;
    mid = (r >= 1) ? line_mid[idx] : p;
    top = (r >= 2) ? line_top[idx] : mid;
    line_top[idx] = line_mid[idx];
    line_mid[idx] = p;
    for (int j = 0; j < 3; j++) begin
      if (c != 0) begin
        win[0][j] = win[1][j];
        win[1][j] = win[2][j];
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (c == 0 || j == 2) begin
        win[j][0] = top;
        win[j][1] = mid;
        win[j][2] = p;
      end
    end
    step_words.delete();
    if (r >= 1) begin
      if (c >= 1) add_word(1'b0, 1'b0, r - 1, c - 1);
      if (lastc) add_word(1'b0, 1'b1, r - 1, c);
    end
    if (lastr) begin
      if (c >= 1) add_word(1'b1, 1'b0, r, c - 1);
      if (lastc) add_word(1'b1, 1'b1, r, c);
    end
    if (step_words.size() != 0) step_words[step_words.size() - 1].last = 1'b1;
    if (lastc) begin
      at_col = 0;
      at_row = lastr ? 0 : r + 1;
    end else begin
      at_col = c + 1;
    end
  endfunction

  function automatic logic [7:0] rand_pixel();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 255;
      default: v = gentle ? int'(last_pix) + $urandom_range(0, 8) - 4 : $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    last_pix = v[7:0];
    return last_pix;
  endfunction

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [CFG_W-1:0] data);
    dir_row_t d;
    d = '0;
    d.kind = ROW_CFG;
    d.idx = idx;
    d.data = data;
    return d;
  endfunction

  // typed results sit at row 0, columns 0 and 1 in order
  function automatic dir_row_t pix_row(row_kind_e kind, logic [7:0] pix, int n,
                                       logic [7:0] m0, logic [7:0] m1);
    dir_row_t d;
    d = '0;
    d.kind = kind;
    d.pix = pix;
    d.n_typed = 3'(n);
    d.mark0 = m0;
    d.mark1 = m1;
    return d;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_WIDTH:  cfg_width = val;
      REG_HEIGHT: cfg_height = val;
      REG_THRESH: cfg_thresh = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    while (edge_words_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [7:0] p, input bit predicted);
    cfg_we_i <= 1'b0;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sobel_step(p);
    pixels_sent++;
    if (predicted) foreach (step_words[i]) edge_words_due.push_back(step_words[i]);
  endtask

  // output side stalls
  always @(posedge clk_i) begin
    if (!idling) begin
      out_ready_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 16);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      got_words.push_back({edge_value_o, out_row_o, out_col_o, last_of_run_o});
  end

  always @(negedge clk_i) begin : check_words
    edge_word_t got, want;
    while (got_words.size() != 0) begin
      got = got_words.pop_front();
      words_checked++;
      if (got.mark == EDGE_ON) edges_seen++;
      if (edge_words_due.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected word, got value %0d row %0d col %0d last %0d",
                 $time, got.mark, got.row, got.col, got.last);
      end else begin
        want = edge_words_due.pop_front();
        if (got !== want) begin
          errors++;
          if (got.mark !== want.mark)
            $display("%0t ns: edge value: expected %0d, got %0d", $time, want.mark, got.mark);
          if (got.row !== want.row)
            $display("%0t ns: row: expected %0d, got %0d", $time, want.row, got.row);
          if (got.col !== want.col)
            $display("%0t ns: col: expected %0d, got %0d", $time, want.col, got.col);
          if (got.last !== want.last)
            $display("%0t ns: last flag: expected %0d, got %0d", $time, want.last, got.last);
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    dir_row_t cur;
    edge_word_t typed;
    bit prev_pix;
    int k, j, n_px, rand_items;
    int unsigned frame_px;
    logic [CFG_W-1:0] new_w;

    dir_tab[0]  = cfg_row(REG_WIDTH, 11'd2);
    dir_tab[1]  = cfg_row(REG_HEIGHT, 11'd1);
    // gradient exactly at the threshold is no edge
    dir_tab[2]  = cfg_row(REG_THRESH, 11'd1020);
    dir_tab[3]  = pix_row(ROW_PIX_TYPED, 8'd0, 0, EDGE_OFF, EDGE_OFF);
    dir_tab[4]  = pix_row(ROW_PIX_TYPED, 8'd255, 2, EDGE_OFF, EDGE_OFF);
    dir_tab[5]  = cfg_row(REG_THRESH, 11'd1019);
    dir_tab[6]  = pix_row(ROW_PIX_TYPED, 8'd0, 0, EDGE_OFF, EDGE_OFF);
    dir_tab[7]  = pix_row(ROW_PIX_TYPED, 8'd255, 2, EDGE_ON, EDGE_ON);
    dir_tab[8]  = pix_row(ROW_PIX_TYPED, 8'd255, 0, EDGE_OFF, EDGE_OFF);
    dir_tab[9]  = pix_row(ROW_PIX_TYPED, 8'd0, 2, EDGE_ON, EDGE_ON);
    dir_tab[10] = cfg_row(REG_THRESH, 11'd0);
    dir_tab[11] = pix_row(ROW_PIX_TYPED, 8'd7, 0, EDGE_OFF, EDGE_OFF);
    dir_tab[12] = pix_row(ROW_PIX_TYPED, 8'd7, 2, EDGE_OFF, EDGE_OFF);
    // single-pixel frames, zero width and height read as one
    dir_tab[13] = cfg_row(REG_WIDTH, 11'd1);
    dir_tab[14] = pix_row(ROW_PIX_TYPED, 8'd200, 1, EDGE_OFF, EDGE_OFF);
    dir_tab[15] = cfg_row(REG_WIDTH, 11'd0);
    dir_tab[16] = pix_row(ROW_PIX_TYPED, 8'd9, 1, EDGE_OFF, EDGE_OFF);
    dir_tab[17] = cfg_row(REG_HEIGHT, 11'd0);
    dir_tab[18] = pix_row(ROW_PIX_TYPED, 8'd1, 1, EDGE_OFF, EDGE_OFF);
    dir_tab[19] = cfg_row(REG_SPARE, 11'd2047);
    dir_tab[20] = pix_row(ROW_PIX_TYPED, 8'd255, 1, EDGE_OFF, EDGE_OFF);
    dir_tab[21] = cfg_row(REG_WIDTH, 11'd3);
    dir_tab[22] = cfg_row(REG_HEIGHT, 11'd3);
    dir_tab[23] = cfg_row(REG_THRESH, 11'd50);
    for (k = 0; k < 9; k++)
      dir_tab[24 + k] = pix_row(ROW_PIX, (k % 2) ? 8'd255 : 8'd0, 0, EDGE_OFF, EDGE_OFF);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset width and threshold, one row per frame
    write_reg(REG_HEIGHT, 11'd1);
    gentle = 1'b1;
    for (k = 0; k < 24; k++) send_pixel(rand_pixel(), 1'b1);
    settle();
    // a column past the new last one closes the row
    write_reg(REG_WIDTH, 11'd1);
    send_pixel(rand_pixel(), 1'b1);
    settle();

    prev_pix = 1'b0;
    for (k = 0; k < DIR_ROWS; k++) begin
      cur = dir_tab[k];
      if (cur.kind == ROW_CFG) begin
        if (prev_pix) settle();
        write_reg(cur.idx, cur.data);
        prev_pix = 1'b0;
      end else begin
        send_pixel(cur.pix, cur.kind == ROW_PIX);
        for (j = 0; j < int'(cur.n_typed); j++) begin
          typed.mark = (j == 0) ? cur.mark0 : cur.mark1;
          typed.row = 10'd0;
          typed.col = 10'(j);
          typed.last = (j == int'(cur.n_typed) - 1);
          edge_words_due.push_back(typed);
        end
        prev_pix = 1'b1;
      end
    end

    rand_items = 0;
    while (rand_items < 200) begin
      settle();
      idling = ($urandom_range(0, 3) != 0);
      gentle = $urandom_range(0, 1);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 15))
          0: new_w = 11'd0;
          1: new_w = 11'd1;
          2: new_w = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
          3: new_w = 11'($urandom_range(1025, 2046));
          default: new_w = 11'($urandom_range(2, 8));
        endcase
        // a wider row mid-frame would read line store entries never written
        if (at_row == 0 || eff_dim(new_w) <= eff_dim(cfg_width)) write_reg(REG_WIDTH, new_w);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: write_reg(REG_HEIGHT, 11'd0);
          1: write_reg(REG_HEIGHT, 11'd1);
          2: write_reg(REG_HEIGHT, 11'($urandom_range(1024, 2047)));
          default: write_reg(REG_HEIGHT, 11'($urandom_range(2, 6)));
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0: write_reg(REG_THRESH, 11'd0);
          1: write_reg(REG_THRESH, 11'd1443);
          2: write_reg(REG_THRESH, 11'd2047);
          3: write_reg(REG_THRESH, 11'($urandom_range(0, 1443)));
          default: write_reg(REG_THRESH, 11'($urandom_range(0, 120)));
        endcase
      end
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, 11'($urandom_range(0, 2047)));
      frame_px = eff_dim(cfg_width) * eff_dim(cfg_height);
      if (frame_px <= 64 && $urandom_range(0, 2) != 0) n_px = frame_px * $urandom_range(1, 2);
      else n_px = $urandom_range(1, 40);
      for (k = 0; k < n_px; k++) send_pixel(rand_pixel(), 1'b1);
      rand_items += n_px;
    end

    // close the open frame, then a full frame back to back
    idling = 1'b0;
    settle();
    write_reg(REG_WIDTH, 11'd1);
    write_reg(REG_HEIGHT, 11'd1);
    send_pixel(rand_pixel(), 1'b1);
    settle();
    write_reg(REG_WIDTH, 11'd9);
    write_reg(REG_HEIGHT, 11'd7);
    write_reg(REG_THRESH, 11'($urandom_range(1, 100)));
    gentle = 1'b0;
    for (k = 0; k < 63; k++) send_pixel(rand_pixel(), 1'b1);

    in_valid_i <= 1'b0;
    while (edge_words_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    $display("streamed %0d pixels, checked %0d result words (%0d marked as edges)",
             pixels_sent, words_checked, edges_seen);
    $display("frames from 1x1 up to clamped sizes, thresholds 0 to 2047, mid-frame changes");
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
